FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Item layouts, status and command codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned RANK_W    = 8;
  localparam int unsigned IN_TAG_W  = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CNT_OUT_W = 5;
  localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [RANK_W-1:0]   item_rank;
    logic [IN_TAG_W-1:0] item_tag;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [RANK_W-1:0]    out_rank;
    logic [IN_TAG_W-1:0]  out_tag;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_item_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              enq_en;
    logic              deq_en;
    logic [RANK_W-1:0] rank;
  } spq_ctl_t;

endpackage

FILE: sv/spq_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_chan_if: valid/ready channel
// Carries one item per accepted handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface spq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one entry; on enqueue keeps, takes the new entry or shifts right,
// on dequeue takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
  parameter int unsigned TAG_BITS = 32
) (
  input  logic                clk_i,
  input  spq_ctl_t            ctl_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic                occ_i,
  input  logic                left_keep_i,
  input  logic [RANK_W-1:0]   left_rank_i,
  input  logic [TAG_BITS-1:0] left_tag_i,
  input  logic [RANK_W-1:0]   right_rank_i,
  input  logic [TAG_BITS-1:0] right_tag_i,
  output logic                keep_o,
  output logic [RANK_W-1:0]   rank_o,
  output logic [TAG_BITS-1:0] tag_o
);

  logic [RANK_W-1:0]   rank_q, rank_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  // equal ranks stay ahead of the new entry
  assign keep_o = occ_i && (rank_q <= ctl_i.rank);

  always_comb begin
    rank_d = rank_q;
    tag_d  = tag_q;
    if (ctl_i.deq_en) begin
      rank_d = right_rank_i;
      tag_d  = right_tag_i;
    end else if (ctl_i.enq_en && !keep_o) begin
      if (left_keep_i) begin
        rank_d = ctl_i.rank;
        tag_d  = new_tag_i;
      end else begin
        rank_d = left_rank_i;
        tag_d  = left_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    tag_q  <= tag_d;
  end

  assign rank_o = rank_q;
  assign tag_o  = tag_q;

endmodule

FILE: sv/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue on a row of cells
//
// in_if carries commands: enqueue (rank, tag) or dequeue. out_if returns one
// result per command: status, the removed entry on a dequeue, and the entry
// count after the command. cfg_we_i/cfg_data_i write the capacity limit,
// which saturates at DEPTH; write it only while the queue is idle.
// Entries sit in DEPTH cells sorted by rank, smallest at cell 0. On an
// enqueue every cell compares its rank with the new one in parallel and the
// row shifts right past the insertion point; a dequeue shifts the row left.
// Throughput is one item per cycle unless out_if stalls; the result
// appears in the output register in the cycle after the item is accepted.
// The cell compare feeds the neighbor select of the row combinationally.
// in_if.ready stays high while the output register is empty or being taken,
// so a stalled receiver holds one result and backpressures the sender.
// Reset empties the queue and sets the capacity to 16; cell contents are
// not cleared, only the fill count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  spq_chan_if.sink         in_if,
  spq_chan_if.source       out_if,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             out_valid_q;
  out_item_t        out_item_q, out_item_d;

  in_item_t      in_item;
  logic          accept;
  logic          is_enq, is_deq;
  logic          full, empty;
  logic [LIM_W-1:0] limit;
  spq_ctl_t      ctl;
  logic [63:0]   tag_in_wide, head_tag_wide;
  logic [TAG_BITS-1:0] new_tag;

  logic [DEPTH-1:0]    occ;
  logic [DEPTH-1:0]    keep;
  logic [RANK_W-1:0]   rank_row [DEPTH];
  logic [TAG_BITS-1:0] tag_row  [DEPTH];

  assign in_item = in_if.payload;
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept = in_if.valid && in_if.ready;
  assign is_enq = in_item.cmd == CMD_ENQ;
  assign is_deq = in_item.cmd == CMD_DEQ;

  assign limit = (LIM_W'(capacity_q) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(capacity_q);
  assign full  = LIM_W'(fill_q) >= limit;
  assign empty = fill_q == '0;

  assign tag_in_wide = 64'(in_item.item_tag);
  assign new_tag     = tag_in_wide[TAG_BITS-1:0];

  assign ctl.enq_en = accept && is_enq && !full;
  assign ctl.deq_en = accept && is_deq && !empty;
  assign ctl.rank   = in_item.item_rank;

  // ---------------- cell row ----------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                left_keep;
    logic [RANK_W-1:0]   left_rank, right_rank;
    logic [TAG_BITS-1:0] left_tag, right_tag;

    assign occ[i] = CNT_W'(i) < fill_q;

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_rank = ctl.rank;
      assign left_tag  = new_tag;
    end else begin : g_mid
      assign left_keep = keep[i-1];
      assign left_rank = rank_row[i-1];
      assign left_tag  = tag_row[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_rank = rank_row[i];
      assign right_tag  = tag_row[i];
    end else begin : g_inner
      assign right_rank = rank_row[i+1];
      assign right_tag  = tag_row[i+1];
    end

    spq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .new_tag_i    (new_tag),
      .occ_i        (occ[i]),
      .left_keep_i  (left_keep),
      .left_rank_i  (left_rank),
      .left_tag_i   (left_tag),
      .right_rank_i (right_rank),
      .right_tag_i  (right_tag),
      .keep_o       (keep[i]),
      .rank_o       (rank_row[i]),
      .tag_o        (tag_row[i])
    );
  end

  // ---------------- count and result ----------------
  assign head_tag_wide = 64'(tag_row[0]);

  always_comb begin
    fill_d = fill_q;
    if (ctl.enq_en) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (ctl.deq_en) begin
      fill_d = fill_q - CNT_W'(1);
    end

    out_item_d             = '0;
    out_item_d.status      = ST_DONE;
    out_item_d.entry_count = CNT_OUT_W'(fill_d);
    if (is_enq) begin
      if (full) begin
        out_item_d.status = ST_FULL;
      end
    end else if (empty) begin
      out_item_d.status = ST_EMPTY;
    end else begin
      out_item_d.out_rank = rank_row[0];
      out_item_d.out_tag  = head_tag_wide[IN_TAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CAPACITY_RST;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_item_q;

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LIM_W'(fill_q) <= LIM_W'(DEPTH))
    else $error("fill count above depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.enq_en |=> fill_q == $past(fill_q) + CNT_W'(1))
    else $error("accepted enqueue did not grow the queue");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= CNT_W'(2)) |-> (rank_row[0] <= rank_row[1]))
    else $error("head of row out of order");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status == ST_EMPTY) |->
      (out_item_q.entry_count == '0 && out_item_q.out_rank == '0))
    else $error("empty status with nonzero fields");

endmodule
